FILE: sv/sfcd_pkg.sv
`default_nettype none
package sfcd_pkg;

    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [10:0] TEMP_MUL   = 11'd1750;
    localparam logic [11:0] TEMP_OFF   = 12'd450;
    localparam logic [10:0] HUM_MUL    = 11'd1250;
    localparam logic [10:0] HUM_OFF    = 11'd60;
    localparam logic [10:0] HUM_MAX    = 11'd1000;
    localparam logic [2:0]  POS_LAST   = 3'd5;

    localparam int TEMP_W = 12;
    localparam int HUM_W  = 10;
    localparam int WORD_W = 16;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [2:0] {
        POS_WORD_HI  = 3'd0,
        POS_WORD_LO  = 3'd1,
        POS_WORD_CRC = 3'd2,
        POS_SEC_HI   = 3'd3,
        POS_SEC_LO   = 3'd4,
        POS_SEC_CRC  = 3'd5
    } byte_pos_t;

    // One completed reply handed from the byte sequencer to the converter.
    typedef struct packed {
        logic                ok;
        logic [WORD_W-1:0]   first_word;
        logic [WORD_W-1:0]   second_word;
    } frame_t;

    // CRC-8, MSB first, one byte folded into the running value.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: sv/sfcd_frame.sv
`default_nettype none
module sfcd_frame (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic [7:0]     s_data,
    output logic                s_ready,
    output logic                frame_valid,
    output sfcd_pkg::frame_t    frame,
    input  wire logic           frame_ready
);
    import sfcd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic        good_reg, good_next;
    logic        fvalid_reg, fvalid_next;
    frame_t      frame_reg, frame_next;
    logic        take;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_upd;

    assign s_ready     = !fvalid_reg || frame_ready;
    assign take        = s_valid && s_ready;
    assign frame_valid = fvalid_reg;
    assign frame       = frame_reg;

    // Positions beyond the last byte cannot occur; treat them as a new reply.
    assign pos_eff = (pos_reg > POS_LAST) ? 3'd0 : pos_reg;

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        first_next  = first_reg;
        second_next = second_reg;
        good_next   = good_reg;
        fvalid_next = fvalid_reg && !frame_ready;
        frame_next  = frame_reg;
        crc_upd     = crc8_feed(crc_reg, s_data);
        if (take) begin
            pos_next = pos_eff + 3'd1;
            unique case (byte_pos_t'(pos_eff))
                POS_WORD_HI: begin
                    crc_next   = crc8_feed(CRC_INIT, s_data);
                    first_next = {s_data, 8'h00};
                end
                POS_WORD_LO: begin
                    crc_next   = crc_upd;
                    first_next = {first_reg[15:8], s_data};
                end
                POS_WORD_CRC: begin
                    good_next = (crc_reg == s_data);
                    crc_next  = CRC_INIT;
                end
                POS_SEC_HI: begin
                    crc_next    = crc8_feed(CRC_INIT, s_data);
                    second_next = {s_data, 8'h00};
                end
                POS_SEC_LO: begin
                    crc_next    = crc_upd;
                    second_next = {second_reg[15:8], s_data};
                end
                default: begin
                    pos_next               = 3'd0;
                    crc_next               = CRC_INIT;
                    fvalid_next            = 1'b1;
                    frame_next.ok          = good_reg && (crc_reg == s_data);
                    frame_next.first_word  = first_reg;
                    frame_next.second_word = second_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 3'd0;
            crc_reg    <= CRC_INIT;
            first_reg  <= '0;
            second_reg <= '0;
            good_reg   <= 1'b0;
            fvalid_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            good_reg   <= good_next;
            fvalid_reg <= fvalid_next;
        end
        frame_reg <= frame_next;
    end

endmodule
`default_nettype wire

FILE: sv/sfcd_convert.sv
`default_nettype none
module sfcd_convert (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         frame_valid,
    input  wire sfcd_pkg::frame_t             frame,
    output logic                              frame_ready,
    output logic                              m_valid,
    output logic                              m_status,
    output logic [sfcd_pkg::TEMP_W-1:0]       m_temp,
    output logic [sfcd_pkg::HUM_W-1:0]        m_hum,
    output logic [31:0]                       m_packed,
    input  wire logic                         m_ready
);
    import sfcd_pkg::*;

    logic              valid_reg, valid_next;
    logic              status_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic [HUM_W-1:0]  hum_reg;
    logic [31:0]       packed_reg;
    logic [26:0]       temp_prod, hum_prod;
    logic [10:0]       hum_raw, hum_sub;
    logic [TEMP_W-1:0] temp_val;
    logic [HUM_W-1:0]  hum_val;
    logic              load;

    assign frame_ready = !valid_reg || m_ready;
    assign load        = frame_valid && frame_ready;
    assign valid_next  = load || (valid_reg && !m_ready);

    always_comb begin
        temp_prod = 27'(frame.first_word) * 27'(TEMP_MUL);
        hum_prod  = 27'(frame.second_word) * 27'(HUM_MUL);
        temp_val  = {1'b0, temp_prod[26:16]} - TEMP_OFF;
        hum_raw   = hum_prod[26:16];
        hum_sub   = hum_raw - HUM_OFF;
        // Readings below the offset clamp to zero rather than wrapping.
        if (hum_raw < HUM_OFF) begin
            hum_val = '0;
        end else if (hum_sub > HUM_MAX) begin
            hum_val = HUM_MAX[HUM_W-1:0];
        end else begin
            hum_val = hum_sub[HUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            status_reg <= !frame.ok;
            temp_reg   <= frame.ok ? temp_val : '0;
            hum_reg    <= frame.ok ? hum_val : '0;
            packed_reg <= frame.ok ? {frame.first_word, frame.second_word} : 32'd0;
        end
    end

    assign m_valid  = valid_reg;
    assign m_status = status_reg;
    assign m_temp   = temp_reg;
    assign m_hum    = hum_reg;
    assign m_packed = packed_reg;

endmodule
`default_nettype wire

FILE: sv/sensor_frame_crc_decoder.sv
// Sensor reply decoder with CRC-8 checking.
// The slave stream carries one reply byte per transfer: a 16-bit word high
// byte first, its CRC-8 byte, then a second word and its CRC-8 byte.
// The CRC uses polynomial 0x31, initial value 0xFF, most significant bit first.
// After every sixth byte the master stream gives one transfer. Its tuser bit
// is the status (0 both CRCs good, 1 a mismatch). Its tdata holds the
// temperature in tenths of a degree, the humidity in tenths of a percent
// clamped to 0..1000, and the two words packed as a serial number. On a
// mismatch the data fields are zero.
// One byte is taken every cycle while s_tready is high. The reply of the
// sixth byte passes through the byte sequencer's frame register and then
// the converter's output register, which is fed by a combinational multiply.
// When the receiver stalls, the two registers fill and s_tready drops only
// once both hold a finished reply; bytes keep flowing otherwise.
// Reset (aresetn low, synchronous) returns the sequencer to the first byte
// of a reply, presets the CRC to 0xFF and drops both valid flags.
`default_nettype none
module sensor_frame_crc_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] reply_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [sfcd_pkg::OUT_DATA_W-1:0] m_tdata,
                                        // [11:0] temperature_tenths, [21:12] humidity_tenths,
                                        // [53:22] packed_word, [55:54] zero
    output logic [0:0]       m_tuser    // [0] status
);
    import sfcd_pkg::*;

    frame_t            frame;
    logic              frame_valid;
    logic              frame_ready;
    logic              status;
    logic [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]  hum;
    logic [31:0]       packed_w;

    // Byte sequencer: tracks the reply position, runs the CRC and collects words.
    sfcd_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_data      (s_tdata),
        .s_ready     (s_tready),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_ready (frame_ready)
    );

    // Converter: scales the words and holds the result for the master side.
    sfcd_convert u_convert (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_ready (frame_ready),
        .m_valid     (m_tvalid),
        .m_status    (status),
        .m_temp      (temp),
        .m_hum       (hum),
        .m_packed    (packed_w),
        .m_ready     (m_tready)
    );

    assign m_tdata = {2'b00, packed_w, hum, temp};
    assign m_tuser = status;

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

// Byte-stream testbench for the sensor reply decoder.
// Reply bytes go in on the slave stream. A predictor in this file follows each
// reply as it arrives: it tracks the byte position, runs the CRC-8 over each
// word and, on every sixth byte, queues the reading that the block should
// give. A checker compares each transfer on the master stream with the oldest
// queued reading, one field at a time.
// The stimulus has two parts. A short directed part covers the field
// extremes, both humidity clamps and CRC errors on either word. A random part
// then sends mostly well-formed replies with random words, mixed with corrupted
// CRC bytes and groups of noise bytes. The sender runs in bursts separated by
// gaps, and the receiver stalls in patterns that change over the run.
module tb;
    import sfcd_pkg::*;

    // A reading as it should leave the block on the master stream.
    typedef struct {
        logic        status;
        logic [11:0] temperature;
        logic [9:0]  humidity;
        logic [31:0] serial;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] reply_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;             // [11:0] temperature_tenths, [21:12] humidity_tenths,
                                      // [53:22] packed_word, [55:54] zero
    logic [0:0]  m_tuser;             // [0] status

    // Readings that the block still owes, oldest first.
    reading_t pending_readings[$];
    int       error_count = 0;

    // Predictor state: where the next byte falls in the reply, the CRC over
    // the word being received, both words, and the verdict on the first CRC.
    byte_pos_t   reply_pos = POS_WORD_HI;
    logic [7:0]  reply_crc = CRC_INIT;
    logic [15:0] hi_word = 16'h0000;
    logic [15:0] lo_word = 16'h0000;
    logic        hi_crc_ok = 1'b0;

    // Sender pacing: bytes left in the current burst.
    int burst_left = 0;

    // Receiver pacing: the current stall pattern and how long it lasts.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;

    sensor_frame_crc_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Hard limit on the run, well beyond what a correct run needs, even
    // with the longest sender gaps and the slowest receiver pattern.
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // One CRC-8 step: polynomial 0x31, most significant bit first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // The check byte the sensor sends after a word.
    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Converts both words into the reading the block should give.
    function automatic reading_t convert_words(input logic [15:0] w1, input logic [15:0] w2);
        reading_t    r;
        logic [31:0] prod;
        int          t;
        int          h;
        prod = 32'(w1) * 32'(TEMP_MUL);
        t = int'(prod >> 16) - int'(TEMP_OFF);
        prod = 32'(w2) * 32'(HUM_MUL);
        h = int'(prod >> 16);
        // Humidity below the offset clamps to zero rather than wrapping.
        h = (h < int'(HUM_OFF)) ? 0 : h - int'(HUM_OFF);
        if (h > int'(HUM_MAX)) begin
            h = int'(HUM_MAX);
        end
        r.status = 1'b0;
        r.temperature = t[11:0];
        r.humidity = h[9:0];
        r.serial = {w1, w2};
        return r;
    endfunction

    // Advances the predictor by one accepted byte. The sixth byte of a reply
    // queues a reading and returns the predictor to the start of a reply.
    task automatic absorb_reply_byte(input logic [7:0] b);
        reading_t r;
        case (reply_pos)
            POS_WORD_HI: begin
                reply_crc = crc8_step(CRC_INIT, b);
                hi_word[15:8] = b;
                reply_pos = POS_WORD_LO;
            end
            POS_WORD_LO: begin
                reply_crc = crc8_step(reply_crc, b);
                hi_word[7:0] = b;
                reply_pos = POS_WORD_CRC;
            end
            POS_WORD_CRC: begin
                hi_crc_ok = (reply_crc == b);
                reply_crc = CRC_INIT;
                reply_pos = POS_SEC_HI;
            end
            POS_SEC_HI: begin
                reply_crc = crc8_step(CRC_INIT, b);
                lo_word[15:8] = b;
                reply_pos = POS_SEC_LO;
            end
            POS_SEC_LO: begin
                reply_crc = crc8_step(reply_crc, b);
                lo_word[7:0] = b;
                reply_pos = POS_SEC_CRC;
            end
            default: begin
                if (hi_crc_ok && (reply_crc == b)) begin
                    r = convert_words(hi_word, lo_word);
                end else begin
                    // Any CRC error zeroes all data fields of the reading.
                    r.status = 1'b1;
                    r.temperature = '0;
                    r.humidity = '0;
                    r.serial = '0;
                end
                pending_readings.push_back(r);
                reply_crc = CRC_INIT;
                reply_pos = POS_WORD_HI;
            end
        endcase
    endtask

    // Sends one byte and waits for its transfer. Called at a rising edge.
    // Once a burst is used up, the sender drops tvalid for a random gap and
    // starts a new burst; long bursts give stretches with no gaps at all.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_tdata <= b;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        absorb_reply_byte(b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Sends a full reply. A corrupted check byte has one random bit flipped.
    task automatic send_reply(input logic [15:0] w1, input logic [15:0] w2,
                              input bit bad_first, input bit bad_second);
        logic [7:0] c1;
        logic [7:0] c2;
        c1 = word_crc(w1);
        c2 = word_crc(w2);
        if (bad_first) begin
            c1 = c1 ^ (8'h01 << $urandom_range(0, 7));
        end
        if (bad_second) begin
            c2 = c2 ^ (8'h01 << $urandom_range(0, 7));
        end
        send_byte(w1[15:8]);
        send_byte(w1[7:0]);
        send_byte(c1);
        send_byte(w2[15:8]);
        send_byte(w2[7:0]);
        send_byte(c2);
    endtask

    // Mostly uniform words, with the conversion edges picked now and then.
    function automatic logic [15:0] pick_word();
        logic [15:0] edges[6];
        edges = '{16'h0000, 16'hFFFF, 16'd3145, 16'd3146, 16'd55574, 16'd55575};
        if ($urandom_range(0, 7) == 0) begin
            return edges[$urandom_range(0, 5)];
        end
        return 16'($urandom);
    endfunction

    // Stops sending until every queued reading has come out.
    task automatic wait_for_readings();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
        end
        while (pending_readings.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Field extremes: coldest reading with humidity clamped to zero, then the
    // hottest with humidity clamped to 1000. The all-zero and all-one bytes
    // appear here too.
    task automatic test_conversion_extremes();
        send_reply(16'h0000, 16'h0000, 1'b0, 1'b0);
        send_reply(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    endtask

    // A bad check byte on the first word, then on the second word only.
    task automatic test_crc_errors();
        send_reply(16'h1234, 16'd55575, 1'b1, 1'b0);
        send_reply(16'd3146, 16'hA5C3, 1'b0, 1'b1);
    endtask

    // Random replies: most are well formed, some carry bad check bytes, and
    // some are six bytes of noise. Noise comes in whole replies so that later
    // well-formed replies still line up with the block's byte count.
    task automatic test_random_replies(input int n_replies);
        int kind;
        int i;
        for (i = 0; i < n_replies; i++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat (6) send_byte(8'($urandom));
            end else if (kind == 1) begin
                case ($urandom_range(0, 2))
                    0: send_reply(pick_word(), pick_word(), 1'b1, 1'b0);
                    1: send_reply(pick_word(), pick_word(), 1'b0, 1'b1);
                    default: send_reply(pick_word(), pick_word(), 1'b1, 1'b1);
                endcase
            end else begin
                send_reply(pick_word(), pick_word(), 1'b0, 1'b0);
            end
        end
    endtask

    // The sender holds off mid-run until the block has delivered everything,
    // then resumes from an idle decoder.
    task automatic test_pause_until_drained();
        wait_for_readings();
        repeat ($urandom_range(3, 12)) @(posedge aclk);
    endtask

    // Receiver stall patterns: always ready, random, mostly stalled, and a
    // fixed one-in-three rhythm. Each lasts a random number of cycles.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
            stall_phase = 0;
        end else begin
            stall_left--;
        end
        stall_phase = (stall_phase + 1) % 3;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_phase == 0);
        endcase
    end

    // Checks each result transfer against the oldest queued reading.
    always @(posedge aclk) begin : check_readings
        reading_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                $error("result transfer with no reading expected");
                error_count++;
            end else begin
                r = pending_readings.pop_front();
                if (m_tuser[0] !== r.status) begin
                    $error("status: expected %0d, actual %0d", r.status, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[11:0] !== r.temperature) begin
                    $error("temperature_tenths: expected %0d, actual %0d",
                           $signed(r.temperature), $signed(m_tdata[11:0]));
                    error_count++;
                end
                if (m_tdata[21:12] !== r.humidity) begin
                    $error("humidity_tenths: expected %0d, actual %0d",
                           r.humidity, m_tdata[21:12]);
                    error_count++;
                end
                if (m_tdata[53:22] !== r.serial) begin
                    $error("packed_word: expected 0x%08h, actual 0x%08h",
                           r.serial, m_tdata[53:22]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_conversion_extremes();
        test_crc_errors();
        test_random_replies(45);
        test_pause_until_drained();
        test_random_replies(43);

        // Drain the block, then keep the clock running to show any stray
        // transfer. Should a reading never come, the hard limit ends the run.
        wait_for_readings();
        repeat (20) @(posedge aclk);

        if (error_count == 0 && pending_readings.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
